// ===== hw/rtl/wsd_pkg.sv =====
`timescale 1ns / 1ps

package wsd_pkg;

  localparam logic [6:0]  LenExt16          = 7'd126;
  localparam logic [6:0]  LenExt64          = 7'd127;
  localparam logic [3:0]  ExtBytes16        = 4'd2;
  localparam logic [3:0]  ExtBytes64        = 4'd8;
  localparam logic [3:0]  MaskKeyBytes      = 4'd4;
  localparam logic [15:0] CaptureLimitReset = 16'd4096;
  localparam int unsigned QueueDepthDefault = 2;

  typedef enum logic [1:0] {
    KindHeader     = 2'd0,
    KindHeaderDone = 2'd1,
    KindPayload    = 2'd2
  } wsd_kind_e;

  typedef struct packed {
    logic [7:0] rx_byte;
  } wsd_rx_t;

  typedef struct packed {
    logic [15:0] capture_limit;
  } wsd_cfg_t;

  // One classified byte, as queued between the parser and the capture stage.
  typedef struct packed {
    wsd_kind_e   event_kind;
    logic        final_flag;
    logic [3:0]  frame_opcode;
    logic        mask_present;
    logic [63:0] payload_length;
    logic [7:0]  payload_byte;
    logic        frame_end;
  } wsd_item_t;

  typedef struct packed {
    wsd_kind_e   event_kind;
    logic        final_flag;
    logic [3:0]  frame_opcode;
    logic        mask_present;
    logic [63:0] payload_length;
    logic [7:0]  payload_byte;
    logic        captured;
    logic        frame_end;
  } wsd_evt_t;

endpackage

// ===== hw/rtl/wsd_stream_if.sv =====
`timescale 1ns / 1ps

interface wsd_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/wsd_front.sv =====
`timescale 1ns / 1ps

module wsd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [7:0]        rx_byte_i,
  output logic              in_ready_o,
  input  logic              queue_full_i,
  output logic              push_o,
  output wsd_pkg::wsd_item_t item_o
);

  typedef enum logic [2:0] {
    PhByte0 = 3'd0,
    PhByte1 = 3'd1,
    PhExt   = 3'd2,
    PhMask  = 3'd3,
    PhPay   = 3'd4
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [63:0] len_q, len_d;
  logic [63:0] rem_q, rem_d;
  logic        fin_q, fin_d;
  logic        mask_q, mask_d;
  logic [3:0]  opc_q, opc_d;
  logic        done;
  logic [63:0] done_len;
  logic        accept;

  assign in_ready_o = ~queue_full_i;
  assign accept     = in_valid_i & ~queue_full_i;
  assign push_o     = accept;

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    len_d    = len_q;
    rem_d    = rem_q;
    fin_d    = fin_q;
    mask_d   = mask_q;
    opc_d    = opc_q;
    done     = 1'b0;
    done_len = len_q;
    item_o.event_kind   = wsd_pkg::KindHeader;
    item_o.payload_byte = 8'd0;
    item_o.frame_end    = 1'b0;

    unique case (phase_q)
      PhByte1: begin
        mask_d = rx_byte_i[7];
        len_d  = 64'd0;
        if (rx_byte_i[6:0] == wsd_pkg::LenExt16) begin
          cnt_d   = wsd_pkg::ExtBytes16;
          phase_d = PhExt;
        end else if (rx_byte_i[6:0] == wsd_pkg::LenExt64) begin
          cnt_d   = wsd_pkg::ExtBytes64;
          phase_d = PhExt;
        end else begin
          len_d = {57'd0, rx_byte_i[6:0]};
          if (rx_byte_i[7]) begin
            cnt_d   = wsd_pkg::MaskKeyBytes;
            phase_d = PhMask;
          end else begin
            done     = 1'b1;
            done_len = {57'd0, rx_byte_i[6:0]};
          end
        end
      end
      PhExt: begin
        len_d = {len_q[55:0], rx_byte_i};
        cnt_d = cnt_q - 4'd1;
        if (cnt_q == 4'd1) begin
          if (mask_q) begin
            cnt_d   = wsd_pkg::MaskKeyBytes;
            phase_d = PhMask;
          end else begin
            done     = 1'b1;
            done_len = {len_q[55:0], rx_byte_i};
          end
        end
      end
      PhMask: begin
        cnt_d = cnt_q - 4'd1;
        if (cnt_q == 4'd1) begin
          done     = 1'b1;
          done_len = len_q;
        end
      end
      PhPay: begin
        item_o.event_kind   = wsd_pkg::KindPayload;
        item_o.payload_byte = rx_byte_i;
        rem_d = rem_q - 64'd1;
        if (rem_q == 64'd1) begin
          item_o.frame_end = 1'b1;
          phase_d          = PhByte0;
        end
      end
      default: begin
        fin_d   = rx_byte_i[7];
        opc_d   = rx_byte_i[3:0];
        mask_d  = 1'b0;
        len_d   = 64'd0;
        rem_d   = 64'd0;
        cnt_d   = 4'd0;
        phase_d = PhByte1;
      end
    endcase

    // A frame without payload ends on its last header byte.
    if (done) begin
      item_o.event_kind = wsd_pkg::KindHeaderDone;
      rem_d             = done_len;
      if (done_len == 64'd0) begin
        item_o.frame_end = 1'b1;
        phase_d          = PhByte0;
      end else begin
        phase_d = PhPay;
      end
    end

    item_o.final_flag     = fin_d;
    item_o.frame_opcode   = opc_d;
    item_o.mask_present   = mask_d;
    item_o.payload_length = len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhByte0;
      cnt_q   <= 4'd0;
      len_q   <= 64'd0;
      rem_q   <= 64'd0;
      fin_q   <= 1'b0;
      mask_q  <= 1'b0;
      opc_q   <= 4'd0;
    end else if (accept) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      rem_q   <= rem_d;
      fin_q   <= fin_d;
      mask_q  <= mask_d;
      opc_q   <= opc_d;
    end
  end

endmodule

// ===== hw/rtl/wsd_queue.sv =====
`timescale 1ns / 1ps

module wsd_queue #(
  parameter int unsigned Depth = wsd_pkg::QueueDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  wsd_pkg::wsd_item_t wr_item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output wsd_pkg::wsd_item_t rd_item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  wsd_pkg::wsd_item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_pop;

  assign full_o    = (count_q == CntW'(Depth));
  assign valid_o   = (count_q != '0);
  assign do_pop    = pop_i & valid_o;
  assign rd_item_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/wsd_back.sv =====
`timescale 1ns / 1ps

module wsd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [15:0]        cfg_limit_i,
  input  logic               item_valid_i,
  input  wsd_pkg::wsd_item_t item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output wsd_pkg::wsd_evt_t  out_o
);

  logic [15:0]       limit_q;
  logic [15:0]       cap_cnt_q, cap_cnt_d;
  logic              out_valid_q;
  wsd_pkg::wsd_evt_t out_q, evt_d;
  logic              take;

  assign pop_o       = ~out_valid_q | out_ready_i;
  assign take        = item_valid_i & pop_o;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    cap_cnt_d            = cap_cnt_q;
    evt_d.event_kind     = item_i.event_kind;
    evt_d.final_flag     = item_i.final_flag;
    evt_d.frame_opcode   = item_i.frame_opcode;
    evt_d.mask_present   = item_i.mask_present;
    evt_d.payload_length = item_i.payload_length;
    evt_d.payload_byte   = item_i.payload_byte;
    evt_d.frame_end      = item_i.frame_end;
    evt_d.captured       = 1'b0;
    // The capture count restarts with every completed header.
    if (item_i.event_kind == wsd_pkg::KindHeaderDone) begin
      cap_cnt_d = 16'd0;
    end else if (item_i.event_kind == wsd_pkg::KindPayload && cap_cnt_q < limit_q) begin
      evt_d.captured = 1'b1;
      cap_cnt_d      = cap_cnt_q + 16'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= evt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= wsd_pkg::CaptureLimitReset;
      cap_cnt_q   <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        limit_q <= cfg_limit_i;
      end
      if (take) begin
        cap_cnt_q <= cap_cnt_d;
      end
      if (pop_o) begin
        out_valid_q <= item_valid_i;
      end
    end
  end

endmodule

// ===== hw/rtl/websocket_frame_deframer_unit.sv =====
`timescale 1ns / 1ps

// Channel   Dir   Word                      Accepted when
// rx_i      in    received stream byte      rx_i.valid and rx_i.ready
// cfg_i     in    capture limit, 16 bits    cfg_i.valid and cfg_i.ready
// evt_o     out   one event per byte        evt_o.valid and evt_o.ready
//
// One byte is accepted per clock while the queue has room; each event is registered.
// The header parser feeds a queue of QueueDepth words, and the capture stage drains it.
// Reset clears the parser, the queue and the output, and sets the capture limit to 4096.
// When evt_o stalls, rx_i keeps accepting until the queue is full.

module websocket_frame_deframer_unit #(
  parameter int unsigned QueueDepth = wsd_pkg::QueueDepthDefault
) (
  input logic          clk_i,
  input logic          rst_ni,
  wsd_stream_if.sink   rx_i,
  wsd_stream_if.sink   cfg_i,
  wsd_stream_if.source evt_o
);

  logic               push;
  logic               full;
  logic               pop;
  logic               q_valid;
  wsd_pkg::wsd_item_t wr_item;
  wsd_pkg::wsd_item_t rd_item;
  wsd_pkg::wsd_rx_t   rx_word;
  wsd_pkg::wsd_cfg_t  cfg_word;
  wsd_pkg::wsd_evt_t  evt_word;

  assign rx_word     = rx_i.data;
  assign cfg_word    = cfg_i.data;
  assign cfg_i.ready = 1'b1;
  assign evt_o.data  = evt_word;

  wsd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (rx_i.valid),
    .rx_byte_i    (rx_word.rx_byte),
    .in_ready_o   (rx_i.ready),
    .queue_full_i (full),
    .push_o       (push),
    .item_o       (wr_item)
  );

  wsd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .wr_item_i (wr_item),
    .full_o    (full),
    .pop_i     (pop),
    .valid_o   (q_valid),
    .rd_item_o (rd_item)
  );

  wsd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_i.valid),
    .cfg_limit_i  (cfg_word.capture_limit),
    .item_valid_i (q_valid),
    .item_i       (rd_item),
    .pop_o        (pop),
    .out_valid_o  (evt_o.valid),
    .out_ready_i  (evt_o.ready),
    .out_o        (evt_word)
  );

endmodule

// ===== test/tb_websocket_frame_deframer_unit.sv =====
`timescale 1ns / 1ps

module tb_websocket_frame_deframer_unit;

  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned DrainCycles   = 20;
  localparam int unsigned ReportLimit   = 10;

  typedef enum logic [2:0] {
    PhHeader0,
    PhHeader1,
    PhExtLength,
    PhMaskKey,
    PhPayload
  } parse_phase_e;

  typedef enum logic [1:0] {
    LenForm7,
    LenForm16,
    LenForm64
  } len_form_e;

  logic clk;
  logic rst_n;

  wsd_stream_if #(.data_t(wsd_pkg::wsd_rx_t))  rx_if ();
  wsd_stream_if #(.data_t(wsd_pkg::wsd_cfg_t)) cfg_if ();
  wsd_stream_if #(.data_t(wsd_pkg::wsd_evt_t)) evt_if ();

  websocket_frame_deframer_unit u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .rx_i   (rx_if),
    .cfg_i  (cfg_if),
    .evt_o  (evt_if)
  );

  // Deframer state as seen by the predictor.
  parse_phase_e ph        = PhHeader0;
  logic [3:0]   hdr_left  = '0;
  logic [63:0]  len_acc   = '0;
  logic [63:0]  pay_left  = '0;
  logic [15:0]  cap_count = '0;
  logic         frame_fin  = 1'b0;
  logic         frame_mask = 1'b0;
  logic [3:0]   frame_op   = '0;
  logic [15:0]  cap_limit  = wsd_pkg::CaptureLimitReset;

  wsd_pkg::wsd_evt_t expected_events[$];
  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  int unsigned idle_cycles = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned evt_stall_pct = 0;
  logic        hold_on = 1'b0;
  event        hold_go;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic finish_header();
    pay_left  = len_acc;
    cap_count = '0;
    if (len_acc == '0) begin
      ph = PhHeader0;
      return 1'b1;
    end
    ph = PhPayload;
    return 1'b0;
  endfunction

  function automatic wsd_pkg::wsd_evt_t deframe_byte(input logic [7:0] b);
    wsd_pkg::wsd_evt_t e;
    e.event_kind   = wsd_pkg::KindHeader;
    e.payload_byte = '0;
    e.captured     = 1'b0;
    e.frame_end    = 1'b0;
    case (ph)
      PhHeader1: begin
        frame_mask = b[7];
        len_acc    = '0;
        if (b[6:0] == wsd_pkg::LenExt16) begin
          hdr_left = wsd_pkg::ExtBytes16;
          ph       = PhExtLength;
        end else if (b[6:0] == wsd_pkg::LenExt64) begin
          hdr_left = wsd_pkg::ExtBytes64;
          ph       = PhExtLength;
        end else begin
          len_acc = 64'(b[6:0]);
          if (frame_mask) begin
            hdr_left = wsd_pkg::MaskKeyBytes;
            ph       = PhMaskKey;
          end else begin
            e.event_kind = wsd_pkg::KindHeaderDone;
            e.frame_end  = finish_header();
          end
        end
      end
      PhExtLength: begin
        len_acc  = {len_acc[55:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == 4'd0) begin
          if (frame_mask) begin
            hdr_left = wsd_pkg::MaskKeyBytes;
            ph       = PhMaskKey;
          end else begin
            e.event_kind = wsd_pkg::KindHeaderDone;
            e.frame_end  = finish_header();
          end
        end
      end
      PhMaskKey: begin
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == 4'd0) begin
          e.event_kind = wsd_pkg::KindHeaderDone;
          e.frame_end  = finish_header();
        end
      end
      PhPayload: begin
        e.event_kind   = wsd_pkg::KindPayload;
        e.payload_byte = b;
        if (cap_count < cap_limit) begin
          e.captured = 1'b1;
          cap_count  = cap_count + 16'd1;
        end
        pay_left = pay_left - 64'd1;
        if (pay_left == '0) begin
          e.frame_end = 1'b1;
          ph          = PhHeader0;
        end
      end
      default: begin
        frame_fin  = b[7];
        frame_mask = 1'b0;
        frame_op   = b[3:0];
        len_acc    = '0;
        pay_left   = '0;
        hdr_left   = '0;
        ph         = PhHeader1;
      end
    endcase
    e.final_flag     = frame_fin;
    e.frame_opcode   = frame_op;
    e.mask_present   = frame_mask;
    e.payload_length = len_acc;
    return e;
  endfunction

  task automatic check_event(input wsd_pkg::wsd_evt_t got);
    wsd_pkg::wsd_evt_t want;
    if (expected_events.size() == 0) begin
      mismatches++;
      if (mismatches <= ReportLimit) begin
        $display("unexpected event at %0t: kind %0d length %h byte %h",
                 $time, got.event_kind, got.payload_length, got.payload_byte);
      end
    end else begin
      want = expected_events.pop_front();
      if (got.event_kind !== want.event_kind || got.final_flag !== want.final_flag ||
          got.frame_opcode !== want.frame_opcode ||
          got.mask_present !== want.mask_present ||
          got.payload_length !== want.payload_length ||
          got.payload_byte !== want.payload_byte || got.captured !== want.captured ||
          got.frame_end !== want.frame_end) begin
        mismatches++;
        if (mismatches <= ReportLimit) begin
          $display("event mismatch at %0t (expected/actual): kind %0d/%0d fin %0b/%0b op %h/%h",
                   $time, want.event_kind, got.event_kind, want.final_flag, got.final_flag,
                   want.frame_opcode, got.frame_opcode);
          $display("  mask %0b/%0b length %h/%h byte %h/%h captured %0b/%0b end %0b/%0b",
                   want.mask_present, got.mask_present, want.payload_length,
                   got.payload_length, want.payload_byte, got.payload_byte,
                   want.captured, got.captured, want.frame_end, got.frame_end);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (evt_if.valid && evt_if.ready) begin
      check_event(evt_if.data);
    end
    evt_if.ready <= !hold_on && ($urandom_range(0, 99) >= evt_stall_pct);
  end

  initial begin
    forever begin
      @(hold_go);
      hold_on <= 1'b1;
      repeat (HoldCycles) @(posedge clk);
      hold_on <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((rx_if.valid && rx_if.ready) || (cfg_if.valid && cfg_if.ready) ||
        (evt_if.valid && evt_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < rx_idle_pct) begin
      rx_if.valid <= 1'b0;
      @(posedge clk);
    end
    rx_if.valid <= 1'b1;
    rx_if.data.rx_byte <= b;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    expected_events.push_back(deframe_byte(b));
    bytes_sent++;
  endtask

  // The last word stays offered after it is accepted, so it is withdrawn first.
  task automatic wait_for_events_done();
    rx_if.valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
  endtask

  task automatic set_capture_limit(input logic [15:0] limit);
    wait_for_events_done();
    cfg_if.valid <= 1'b1;
    cfg_if.data.capture_limit <= limit;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    cap_limit = limit;
  endtask

  task automatic send_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                            input logic mask, input len_form_e form,
                            input logic [63:0] len, input int unsigned pay_n);
    send_byte({fin, rsv, op});
    case (form)
      LenForm7: begin
        send_byte({mask, len[6:0]});
      end
      LenForm16: begin
        send_byte({mask, wsd_pkg::LenExt16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({mask, wsd_pkg::LenExt64});
        for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
      end
    endcase
    if (mask) repeat (wsd_pkg::MaskKeyBytes) send_byte(8'($urandom));
    repeat (pay_n) send_byte(8'($urandom));
  endtask

  // Random bytes that keep any extended length small, so the stream resyncs soon.
  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if (ph == PhExtLength) begin
      if (hdr_left > 4'd1) b = 8'h00;
      else b = b & 8'h3F;
    end
    return b;
  endfunction

  task automatic random_frames(input int unsigned n);
    int unsigned start;
    int unsigned r;
    len_form_e   form;
    logic [63:0] len;
    start = bytes_sent;
    while (bytes_sent - start < n) begin
      if ($urandom_range(0, 99) < 10) begin
        repeat ($urandom_range(1, 6)) send_byte(noise_byte());
        while (ph != PhHeader0) send_byte(noise_byte());
      end else begin
        r = $urandom_range(0, 99);
        form = (r < 70) ? LenForm7 : (r < 85) ? LenForm16 : LenForm64;
        if (form == LenForm7) begin
          len = ($urandom_range(0, 99) < 90) ? 64'($urandom_range(0, 12))
                                             : 64'($urandom_range(0, 125));
        end else begin
          len = ($urandom_range(0, 99) < 90) ? 64'($urandom_range(0, 40))
                                             : 64'($urandom_range(0, 300));
        end
        send_frame(1'($urandom), 3'($urandom), 4'($urandom), 1'($urandom), form, len,
                   32'(len));
      end
    end
  endtask

  task automatic test_zero_length();
    send_byte(8'h81);
    send_byte(8'h00);
  endtask

  task automatic test_reserved_bits();
    send_byte(8'h7A);
    send_byte(8'h02);
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  task automatic test_limit_change_mid_frame();
    set_capture_limit(16'h0000);
    send_byte(8'h88);
    send_byte(8'hFE);
    send_byte(8'h00);
    send_byte(8'h02);
    repeat (wsd_pkg::MaskKeyBytes) send_byte(8'($urandom));
    send_byte(8'h5A);
    set_capture_limit(16'hFFFF);
    send_byte(8'hA5);
  endtask

  task automatic test_random_traffic();
    set_capture_limit(16'($urandom));
    rx_idle_pct   = 0;
    evt_stall_pct = 0;
    random_frames(350);
    set_capture_limit(16'h0000);
    rx_idle_pct   = 68;
    evt_stall_pct = 0;
    random_frames(350);
    set_capture_limit(16'hFFFF);
    rx_idle_pct   = 0;
    evt_stall_pct = 68;
    random_frames(350);
    set_capture_limit(16'($urandom_range(0, 8)));
    rx_idle_pct   = 20;
    evt_stall_pct = 20;
    random_frames(350);
  endtask

  task automatic test_backpressure();
    wait_for_events_done();
    rx_idle_pct   = 0;
    evt_stall_pct = 0;
    -> hold_go;
    random_frames(60);
    wait_for_events_done();
  endtask

  task automatic test_ext64_top_bit();
    send_frame(1'b1, 3'b000, 4'h2, 1'b0, LenForm64, 64'hF0E1_D2C3_B4A5_9687, 3);
  endtask

  initial begin
    rst_n         = 1'b0;
    rx_if.valid   = 1'b0;
    rx_if.data    = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.data   = '0;
    evt_if.ready  = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_zero_length();
    test_reserved_bits();
    test_limit_change_mid_frame();
    test_random_traffic();
    test_backpressure();
    test_ext64_top_bit();

    wait_for_events_done();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
